@@ rtl/tcp_pkg.sv @@
`default_nettype none
// ============================================================================
// Tilted camera projection package
// Shared word types, register map, fixed constants and the divider step.
// ============================================================================
package tcp_pkg;

  // Input word: one 3D point, Q15.8 each.
  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } tcp_in_t;

  // Result word: pixel position in Q11.4 and a valid flag.
  typedef struct packed {
    logic signed [15:0] pixel_col;
    logic signed [15:0] pixel_row;
    logic               valid_res;
  } tcp_out_t;

  // Status that travels down the pipeline with each word.
  typedef struct packed {
    logic pos;  // rotated depth is positive
    logic ok;   // no clamp or saturation so far
  } tcp_flags_t;

  typedef struct packed {
    logic        [19:0] focal_x;
    logic        [19:0] focal_y;
    logic        [19:0] center_x;
    logic        [19:0] center_y;
    logic signed [17:0] radial_k1;
    logic signed [17:0] radial_k2;
    logic signed [17:0] tangential_p1;
    logic signed [17:0] tangential_p2;
  } tcp_cfg_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } tcp_reg_t;

  localparam logic signed [20:0] COS_Q20 = 21'sd1017429;  // cos(14 deg)
  localparam logic signed [20:0] SIN_Q20 = 21'sd253673;   // sin(14 deg)
  localparam logic signed [16:0] K3_Q16  = 17'sd50921;    // fixed third radial term

  localparam int DIV_STAGES = 13;  // two quotient bits per stage, 26 bits total
  localparam int DST_STAGES = 14;

  // Two steps of restoring division. The remainder stays below the divisor.
  function automatic logic [33:0] div_step2(input logic [31:0] rem,
                                            input logic [1:0]  bits,
                                            input logic [31:0] d);
    logic [32:0] t;
    logic [31:0] r;
    logic        q1;
    logic        q0;
    t  = {rem, bits[1]};
    q1 = (t >= {1'b0, d});
    r  = q1 ? 32'(t - {1'b0, d}) : t[31:0];
    t  = {r, bits[0]};
    q0 = (t >= {1'b0, d});
    r  = q0 ? 32'(t - {1'b0, d}) : t[31:0];
    return {r, q1, q0};
  endfunction

endpackage
`default_nettype wire

@@ rtl/tilted_camera_point_projection_unit.sv @@
`default_nettype none
// ============================================================================
// Tilted camera point projection unit
// Projects 3D points through a 14 degree tilt and a Brown-Conrady lens model
// to pixel coordinates, with an APB-style register port for the intrinsics.
// ============================================================================
// Throughput: one word per cycle while the output is not stalled; the rate is set
// by the fully pipelined divider (two quotient bits per stage) and multipliers.
// The whole pipeline advances together when the output register is free
// or is being read. Synchronous active-low reset clears all valid bits and
// loads the register defaults; no clearing pass is needed.
module tilted_camera_point_projection_unit import tcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire tcp_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output tcp_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tcp_cfg_t cfg_r;
  logic     wr_en;
  logic     adv;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x       <= 20'd171408;
      cfg_r.focal_y       <= 20'd173694;
      cfg_r.center_x      <= 20'd106957;
      cfg_r.center_y      <= 20'd69024;
      cfg_r.radial_k1     <= 18'sd7128;
      cfg_r.radial_k2     <= -18'sd33192;
      cfg_r.tangential_p1 <= -18'sd1060;
      cfg_r.tangential_p2 <= 18'sd635;
    end else if (wr_en) begin
      case (tcp_reg_t'(paddr[4:2]))
        REG_FOCAL_X:  cfg_r.focal_x       <= pwdata[19:0];
        REG_FOCAL_Y:  cfg_r.focal_y       <= pwdata[19:0];
        REG_CENTER_X: cfg_r.center_x      <= pwdata[19:0];
        REG_CENTER_Y: cfg_r.center_y      <= pwdata[19:0];
        REG_K1:       cfg_r.radial_k1     <= $signed(pwdata[17:0]);
        REG_K2:       cfg_r.radial_k2     <= $signed(pwdata[17:0]);
        REG_P1:       cfg_r.tangential_p1 <= $signed(pwdata[17:0]);
        REG_P2:       cfg_r.tangential_p2 <= $signed(pwdata[17:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tcp_reg_t'(paddr[4:2]))
      REG_FOCAL_X:  prdata = {12'd0, cfg_r.focal_x};
      REG_FOCAL_Y:  prdata = {12'd0, cfg_r.focal_y};
      REG_CENTER_X: prdata = {12'd0, cfg_r.center_x};
      REG_CENTER_Y: prdata = {12'd0, cfg_r.center_y};
      REG_K1:       prdata = 32'(cfg_r.radial_k1);
      REG_K2:       prdata = 32'(cfg_r.radial_k2);
      REG_P1:       prdata = 32'(cfg_r.tangential_p1);
      REG_P2:       prdata = 32'(cfg_r.tangential_p2);
      default:      prdata = '0;
    endcase
  end

  // The output register is the last stage; everything moves when it frees up.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic        fr_valid;
  tcp_flags_t  fr_flags;
  logic [31:0] fr_div;
  logic [55:0] fr_num_x, fr_num_y;
  logic        fr_neg_x, fr_neg_y;

  tcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_i   (in_valid),
    .data_i    (in_data),
    .valid_o   (fr_valid),
    .flags_o   (fr_flags),
    .divisor_o (fr_div),
    .num_x_o   (fr_num_x),
    .num_y_o   (fr_num_y),
    .neg_x_o   (fr_neg_x),
    .neg_y_o   (fr_neg_y)
  );

  logic               dv_valid;
  tcp_flags_t         dv_flags;
  logic signed [26:0] dv_xn, dv_yn;

  tcp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_i   (fr_valid),
    .flags_i   (fr_flags),
    .divisor_i (fr_div),
    .num_x_i   (fr_num_x),
    .num_y_i   (fr_num_y),
    .neg_x_i   (fr_neg_x),
    .neg_y_i   (fr_neg_y),
    .valid_o   (dv_valid),
    .flags_o   (dv_flags),
    .xn_o      (dv_xn),
    .yn_o      (dv_yn)
  );

  logic               ds_valid;
  tcp_flags_t         ds_flags;
  logic signed [39:0] ds_dx, ds_dy;

  tcp_distort u_distort (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (dv_valid),
    .flags_i (dv_flags),
    .cfg     (cfg_r),
    .xn_i    (dv_xn),
    .yn_i    (dv_yn),
    .valid_o (ds_valid),
    .flags_o (ds_flags),
    .dx_o    (ds_dx),
    .dy_o    (ds_dy)
  );

  tcp_pixel u_pixel (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (ds_valid),
    .flags_i (ds_flags),
    .cfg     (cfg_r),
    .dx_i    (ds_dx),
    .dy_i    (ds_dy),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/tcp_front.sv @@
`default_nettype none
// ============================================================================
// Tilt rotation front end
// Rotates the point about the x axis, rounds to Q16 and prepares the
// dividend magnitudes and the divisor for the divider.
// ============================================================================
module tcp_front import tcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        valid_i,
  input  wire tcp_in_t     data_i,
  output logic             valid_o,
  output tcp_flags_t       flags_o,
  output logic [31:0]      divisor_o,
  output logic [55:0]      num_x_o,
  output logic [55:0]      num_y_o,
  output logic             neg_x_o,
  output logic             neg_y_o
);

  logic               v1_r, v2_r;
  logic signed [23:0] x1_r;
  logic signed [45:0] pyc_r, pzs_r, pys_r, pzc_r;

  logic signed [46:0] yr28_nxt, zr28_nxt;
  logic signed [34:0] yr16_nxt, zr16_nxt, ymag_nxt;
  logic signed [24:0] xmag_nxt;

  tcp_flags_t  flags_r;
  logic [31:0] div_r;
  logic [55:0] nx_r, ny_r;
  logic        negx_r, negy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= data_i.point_x;
      pyc_r <= 46'(data_i.point_y) * 46'(COS_Q20);
      pzs_r <= 46'(data_i.point_z) * 46'(SIN_Q20);
      pys_r <= 46'(data_i.point_y) * 46'(SIN_Q20);
      pzc_r <= 46'(data_i.point_z) * 46'(COS_Q20);
    end
  end

  always_comb begin
    yr28_nxt = 47'(pyc_r) - 47'(pzs_r);
    zr28_nxt = 47'(pys_r) + 47'(pzc_r);
    yr16_nxt = 35'((yr28_nxt + 47'sd2048) >>> 12);
    zr16_nxt = 35'((zr28_nxt + 47'sd2048) >>> 12);
    ymag_nxt = (yr16_nxt < 35'sd0) ? -yr16_nxt : yr16_nxt;
    xmag_nxt = (x1_r < 24'sd0) ? -25'(x1_r) : 25'(x1_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flags_r.pos <= (zr28_nxt > 47'sd0);
      flags_r.ok  <= 1'b1;
      // A depth that rounds to zero or below divides by one LSB instead.
      div_r  <= (zr16_nxt < 35'sd1) ? 32'd1 : zr16_nxt[31:0];
      nx_r   <= {xmag_nxt[23:0], 32'd0};
      ny_r   <= {ymag_nxt[31:0], 24'd0};
      negx_r <= (x1_r < 24'sd0);
      negy_r <= (yr16_nxt < 35'sd0);
    end
  end

  assign valid_o   = v2_r;
  assign flags_o   = flags_r;
  assign divisor_o = div_r;
  assign num_x_o   = nx_r;
  assign num_y_o   = ny_r;
  assign neg_x_o   = negx_r;
  assign neg_y_o   = negy_r;

endmodule
`default_nettype wire

@@ rtl/tcp_div.sv @@
`default_nettype none
// ============================================================================
// Pipelined depth divider
// Two lanes share one divisor. Each stage retires two quotient bits; a final
// stage clamps the normalized coordinates to +-2 and applies the sign.
// ============================================================================
module tcp_div import tcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              valid_i,
  input  wire tcp_flags_t        flags_i,
  input  wire logic [31:0]       divisor_i,
  input  wire logic [55:0]       num_x_i,
  input  wire logic [55:0]       num_y_i,
  input  wire logic              neg_x_i,
  input  wire logic              neg_y_i,
  output logic                   valid_o,
  output tcp_flags_t             flags_o,
  output logic signed [26:0]     xn_o,
  output logic signed [26:0]     yn_o
);

  localparam logic [25:0] NORM_CAP = 26'd33554432;

  logic [55:0] num [2];
  logic        neg [2];

  logic [31:0] rem_q [DIV_STAGES][2];
  logic [25:0] quo_q [DIV_STAGES][2];
  logic [25:0] low_q [DIV_STAGES][2];
  logic        ovf_q [DIV_STAGES][2];
  logic        neg_q [DIV_STAGES][2];
  logic [31:0] d_q   [DIV_STAGES];
  logic        v_q   [DIV_STAGES];
  tcp_flags_t  fl_q  [DIV_STAGES];

  assign num[0] = num_x_i;
  assign num[1] = num_y_i;
  assign neg[0] = neg_x_i;
  assign neg[1] = neg_y_i;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [31:0] d_in;
    logic        v_in;
    tcp_flags_t  fl_in;
    logic [31:0] d_r;
    logic        v_r;
    tcp_flags_t  fl_r;

    if (s == 0) begin : g_head
      assign d_in  = divisor_i;
      assign v_in  = valid_i;
      assign fl_in = flags_i;
    end else begin : g_body
      assign d_in  = d_q[s-1];
      assign v_in  = v_q[s-1];
      assign fl_in = fl_q[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_r  <= d_in;
        fl_r <= fl_in;
      end
    end

    assign d_q[s]  = d_r;
    assign v_q[s]  = v_r;
    assign fl_q[s] = fl_r;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [31:0] rem_in;
      logic [25:0] quo_in;
      logic [25:0] low_in;
      logic        ovf_in;
      logic        neg_in;
      logic [33:0] step;
      logic [31:0] rem_r;
      logic [25:0] quo_r;
      logic [25:0] low_r;
      logic        ovf_r;
      logic        neg_r;

      if (s == 0) begin : g_head
        assign rem_in = {2'b00, num[l][55:26]};
        assign quo_in = '0;
        assign low_in = num[l][25:0];
        // A quotient of 2^26 or more is beyond the clamp anyway.
        assign ovf_in = ({2'b00, num[l][55:26]} >= d_in);
        assign neg_in = neg[l];
      end else begin : g_body
        assign rem_in = rem_q[s-1][l];
        assign quo_in = quo_q[s-1][l];
        assign low_in = low_q[s-1][l];
        assign ovf_in = ovf_q[s-1][l];
        assign neg_in = neg_q[s-1][l];
      end

      assign step = div_step2(rem_in, low_in[25-2*s -: 2], d_in);

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r <= step[33:2];
          quo_r <= {quo_in[23:0], step[1:0]};
          low_r <= low_in;
          ovf_r <= ovf_in;
          neg_r <= neg_in;
        end
      end

      assign rem_q[s][l] = rem_r;
      assign quo_q[s][l] = quo_r;
      assign low_q[s][l] = low_r;
      assign ovf_q[s][l] = ovf_r;
      assign neg_q[s][l] = neg_r;
    end
  end

  logic              big_nxt [2];
  logic [25:0]       mag_nxt [2];
  logic signed [26:0] val_nxt [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      big_nxt[l] = ovf_q[DIV_STAGES-1][l] || (quo_q[DIV_STAGES-1][l] > NORM_CAP);
      mag_nxt[l] = big_nxt[l] ? NORM_CAP : quo_q[DIV_STAGES-1][l];
      val_nxt[l] = neg_q[DIV_STAGES-1][l] ? -$signed({1'b0, mag_nxt[l]})
                                          : $signed({1'b0, mag_nxt[l]});
    end
  end

  logic        vo_r;
  tcp_flags_t  flo_r;
  logic signed [26:0] xn_r, yn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= v_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xn_r      <= val_nxt[0];
      yn_r      <= val_nxt[1];
      flo_r.pos <= fl_q[DIV_STAGES-1].pos;
      flo_r.ok  <= fl_q[DIV_STAGES-1].ok && !big_nxt[0] && !big_nxt[1];
    end
  end

  assign valid_o = vo_r;
  assign flags_o = flo_r;
  assign xn_o    = xn_r;
  assign yn_o    = yn_r;

endmodule
`default_nettype wire

@@ rtl/tcp_distort.sv @@
`default_nettype none
// ============================================================================
// Lens distortion pipeline
// Radial scaling with k1, k2 and the fixed k3, then the tangential terms on
// the scaled coordinates. Multiplies and round-and-add steps sit in separate stages.
// ============================================================================
module tcp_distort import tcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              valid_i,
  input  wire tcp_flags_t        flags_i,
  input  wire tcp_cfg_t          cfg,
  input  wire logic signed [26:0] xn_i,
  input  wire logic signed [26:0] yn_i,
  output logic                   valid_o,
  output tcp_flags_t             flags_o,
  output logic signed [39:0]     dx_o,
  output logic signed [39:0]     dy_o
);

  localparam int CLAMP_STAGE = 9;
  localparam logic signed [40:0] SCALED_LIM = 41'sd134217728;

  logic       v_r  [DST_STAGES];
  tcp_flags_t fl_r [DST_STAGES];

  logic signed [40:0] rx_nxt, ry_nxt;
  logic               clip_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DST_STAGES; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= valid_i;
      for (int i = 1; i < DST_STAGES; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_r[0] <= flags_i;
      for (int i = 1; i < DST_STAGES; i++) begin
        if (i != CLAMP_STAGE) fl_r[i] <= fl_r[i-1];
      end
      // The clamp of the scaled coordinates joins the status at its own stage.
      fl_r[CLAMP_STAGE].pos <= fl_r[CLAMP_STAGE-1].pos;
      fl_r[CLAMP_STAGE].ok  <= fl_r[CLAMP_STAGE-1].ok && !clip_nxt;
    end
  end

  // Stage registers, named by stage letter.
  logic signed [26:0] a_xn_r, a_yn_r, b_xn_r, b_yn_r, c_xn_r, c_yn_r, d_xn_r, d_yn_r;
  logic signed [26:0] e_xn_r, e_yn_r, f_xn_r, f_yn_r, g_xn_r, g_yn_r, h_xn_r, h_yn_r;
  logic signed [53:0] a_xx_r, a_yy_r;
  logic signed [28:0] b_r2_r, c_r2_r, d_r2_r, e_r2_r, f_r2_r, g_r2_r, h_r2_r;
  logic signed [28:0] i_r2_r, j_r2_r, k_r2_r;
  logic signed [57:0] c_p4_r;
  logic signed [46:0] c_pk1_r, d_pk1_r, e_pk1_r;
  logic signed [31:0] d_r4_r;
  logic signed [61:0] e_p6_r;
  logic signed [49:0] e_pk2_r;
  logic signed [35:0] f_r6_r;
  logic signed [50:0] f_s12_r, g_s12_r;
  logic signed [52:0] g_pk3_r;
  logic signed [37:0] h_f_r;
  logic signed [64:0] i_mx_r, i_my_r;
  logic signed [28:0] j_xs_r, j_ys_r, k_xs_r, k_ys_r, l_xs_r, l_ys_r, m_xs_r, m_ys_r;
  logic signed [57:0] k_pxy_r, k_pxx_r, k_pyy_r;
  logic signed [35:0] l_txy_r, l_sx_r, l_sy_r;
  logic signed [53:0] m_q1_r, m_q2_r, m_q3_r, m_q4_r;
  logic signed [39:0] n_dx_r, n_dy_r;

  logic signed [53:0] h_sum_nxt;
  logic signed [33:0] l_xy_nxt, l_xx_nxt, l_yy_nxt;

  always_comb begin
    rx_nxt   = 41'((i_mx_r + 65'sd8388608) >>> 24);
    ry_nxt   = 41'((i_my_r + 65'sd8388608) >>> 24);
    clip_nxt = (rx_nxt > SCALED_LIM) || (rx_nxt < -SCALED_LIM) ||
               (ry_nxt > SCALED_LIM) || (ry_nxt < -SCALED_LIM);
    h_sum_nxt = 54'(g_s12_r) + 54'(g_pk3_r);
    l_xy_nxt  = 34'((k_pxy_r + 58'sd8388608) >>> 24);
    l_xx_nxt  = 34'((k_pxx_r + 58'sd8388608) >>> 24);
    l_yy_nxt  = 34'((k_pyy_r + 58'sd8388608) >>> 24);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // a: squares of the normalized coordinates
      a_xx_r <= 54'(xn_i) * 54'(xn_i);
      a_yy_r <= 54'(yn_i) * 54'(yn_i);
      a_xn_r <= xn_i;
      a_yn_r <= yn_i;
      // b: r2
      b_r2_r <= 29'((55'(a_xx_r) + 55'(a_yy_r) + 55'sd8388608) >>> 24);
      b_xn_r <= a_xn_r;
      b_yn_r <= a_yn_r;
      // c: r2 squared, k1 term
      c_p4_r  <= 58'(b_r2_r) * 58'(b_r2_r);
      c_pk1_r <= 47'(cfg.radial_k1) * 47'(b_r2_r);
      c_r2_r  <= b_r2_r;
      c_xn_r  <= b_xn_r;
      c_yn_r  <= b_yn_r;
      // d: r4
      d_r4_r  <= 32'((c_p4_r + 58'sd8388608) >>> 24);
      d_pk1_r <= c_pk1_r;
      d_r2_r  <= c_r2_r;
      d_xn_r  <= c_xn_r;
      d_yn_r  <= c_yn_r;
      // e: r4 times r2, k2 term
      e_p6_r  <= 62'(d_r4_r) * 62'(d_r2_r);
      e_pk2_r <= 50'(cfg.radial_k2) * 50'(d_r4_r);
      e_pk1_r <= d_pk1_r;
      e_r2_r  <= d_r2_r;
      e_xn_r  <= d_xn_r;
      e_yn_r  <= d_yn_r;
      // f: r6, partial radial sum
      f_r6_r  <= 36'((e_p6_r + 62'sd8388608) >>> 24);
      f_s12_r <= 51'(e_pk1_r) + 51'(e_pk2_r);
      f_r2_r  <= e_r2_r;
      f_xn_r  <= e_xn_r;
      f_yn_r  <= e_yn_r;
      // g: k3 term
      g_pk3_r <= 53'(K3_Q16) * 53'(f_r6_r);
      g_s12_r <= f_s12_r;
      g_r2_r  <= f_r2_r;
      g_xn_r  <= f_xn_r;
      g_yn_r  <= f_yn_r;
      // h: radial factor in Q24
      h_f_r  <= 38'sd16777216 + 38'((h_sum_nxt + 54'sd32768) >>> 16);
      h_r2_r <= g_r2_r;
      h_xn_r <= g_xn_r;
      h_yn_r <= g_yn_r;
      // i: radial scaling
      i_mx_r <= 65'(h_xn_r) * 65'(h_f_r);
      i_my_r <= 65'(h_yn_r) * 65'(h_f_r);
      i_r2_r <= h_r2_r;
      // j: round and clamp to +-8
      j_xs_r <= (rx_nxt > SCALED_LIM) ? 29'sd134217728 :
                (rx_nxt < -SCALED_LIM) ? -29'sd134217728 : 29'(rx_nxt);
      j_ys_r <= (ry_nxt > SCALED_LIM) ? 29'sd134217728 :
                (ry_nxt < -SCALED_LIM) ? -29'sd134217728 : 29'(ry_nxt);
      j_r2_r <= i_r2_r;
      // k: tangential products
      k_pxy_r <= 58'(j_xs_r) * 58'(j_ys_r);
      k_pxx_r <= 58'(j_xs_r) * 58'(j_xs_r);
      k_pyy_r <= 58'(j_ys_r) * 58'(j_ys_r);
      k_xs_r  <= j_xs_r;
      k_ys_r  <= j_ys_r;
      k_r2_r  <= j_r2_r;
      // l: round products, form the coefficient operands
      l_txy_r <= 36'sd2 * 36'(l_xy_nxt);
      l_sx_r  <= 36'(k_r2_r) + 36'sd2 * 36'(l_xx_nxt);
      l_sy_r  <= 36'(k_r2_r) + 36'sd2 * 36'(l_yy_nxt);
      l_xs_r  <= k_xs_r;
      l_ys_r  <= k_ys_r;
      // m: coefficient products
      m_q1_r <= 54'(cfg.tangential_p1) * 54'(l_txy_r);
      m_q2_r <= 54'(cfg.tangential_p2) * 54'(l_sx_r);
      m_q3_r <= 54'(cfg.tangential_p2) * 54'(l_txy_r);
      m_q4_r <= 54'(cfg.tangential_p1) * 54'(l_sy_r);
      m_xs_r <= l_xs_r;
      m_ys_r <= l_ys_r;
      // n: distorted coordinates
      n_dx_r <= 40'(m_xs_r) + 40'((55'(m_q1_r) + 55'(m_q2_r) + 55'sd32768) >>> 16);
      n_dy_r <= 40'(m_ys_r) + 40'((55'(m_q3_r) + 55'(m_q4_r) + 55'sd32768) >>> 16);
    end
  end

  assign valid_o = v_r[DST_STAGES-1];
  assign flags_o = fl_r[DST_STAGES-1];
  assign dx_o    = n_dx_r;
  assign dy_o    = n_dy_r;

endmodule
`default_nettype wire

@@ rtl/tcp_pixel.sv @@
`default_nettype none
// ============================================================================
// Pixel mapping and output register
// Scales by the focal lengths, adds the principal point, rounds to Q4 and
// saturates. The second stage is the output register.
// ============================================================================
module tcp_pixel import tcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              valid_i,
  input  wire tcp_flags_t        flags_i,
  input  wire tcp_cfg_t          cfg,
  input  wire logic signed [39:0] dx_i,
  input  wire logic signed [39:0] dy_i,
  output logic                   valid_o,
  output tcp_out_t               data_o
);

  logic               v1_r, v2_r;
  tcp_flags_t         fl1_r;
  logic signed [61:0] cx_r, cy_r;
  tcp_out_t           out_r;

  logic signed [61:0] sx_nxt, sy_nxt;
  logic signed [33:0] col_nxt, row_nxt;
  logic               sat_nxt;
  tcp_out_t           out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    sx_nxt  = cx_r + (62'($signed({1'b0, cfg.center_x})) <<< 24);
    sy_nxt  = cy_r + (62'($signed({1'b0, cfg.center_y})) <<< 24);
    col_nxt = 34'((sx_nxt + 62'sd134217728) >>> 28);
    row_nxt = 34'((sy_nxt + 62'sd134217728) >>> 28);
    sat_nxt = (col_nxt > 34'sd32767) || (col_nxt < -34'sd32768) ||
              (row_nxt > 34'sd32767) || (row_nxt < -34'sd32768);
    out_nxt.pixel_col = (col_nxt > 34'sd32767) ? 16'sd32767 :
                        (col_nxt < -34'sd32768) ? -16'sd32768 : 16'(col_nxt);
    out_nxt.pixel_row = (row_nxt > 34'sd32767) ? 16'sd32767 :
                        (row_nxt < -34'sd32768) ? -16'sd32768 : 16'(row_nxt);
    out_nxt.valid_res = fl1_r.ok && !sat_nxt;
    // A point at or behind the camera gives an all-zero word.
    if (!fl1_r.pos) begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r  <= 62'(dx_i) * 62'($signed({1'b0, cfg.focal_x}));
      cy_r  <= 62'(dy_i) * 62'($signed({1'b0, cfg.focal_y}));
      fl1_r <= flags_i;
      out_r <= out_nxt;
    end
  end

  assign valid_o = v2_r;
  assign data_o  = out_r;

endmodule
`default_nettype wire

@@ rtl/tcp_checker.sv @@
`default_nettype none
// ============================================================================
// Projection unit checker
// Port-level checks on the result handshake and the pipeline back-pressure.
// ============================================================================
module tcp_checker import tcp_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire tcp_out_t out_data
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The pipeline stops taking input only while a result is held.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although result side is ready");

endmodule

bind tilted_camera_point_projection_unit tcp_checker u_tcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ tb/tilted_camera_point_projection_unit_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Tilted camera point projection unit testbench
// Streams directed and random 3D points through the unit under several lens
// and intrinsic settings, predicts each pixel word in 64-bit integer math and
// compares every field of every result word in order.
// ============================================================================
module tilted_camera_point_projection_unit_test;
  import tcp_pkg::*;

  localparam longint NORM_LIM   = 64'sd1 << 25;
  localparam longint SCALED_LIM = 64'sd1 << 27;
  localparam longint ONE_Q24    = 64'sd1 << 24;
  localparam int     WATCHDOG   = 2000;
  localparam int     N_RANDOM   = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tcp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tcp_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tcp_cfg_t lens;
  tcp_out_t pixel_queue[$];
  int       errors = 0;
  int       points_sent = 0;
  int       words_seen = 0;
  int       invalid_seen = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;

  typedef struct {
    tcp_in_t  pt;
    bit       typed;
    tcp_out_t want;
  } point_row_t;

  always #5 clk = ~clk;

  tilted_camera_point_projection_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi, ref bit ok);
    if (v < lo) begin
      ok = 1'b0;
      return lo;
    end
    if (v > hi) begin
      ok = 1'b0;
      return hi;
    end
    return v;
  endfunction

  function automatic tcp_out_t project_point(tcp_in_t p);
    longint x, y, z, yr28, zr28, zr16, yr16, x16, xn, yn, r2, r4, r6, f;
    longint xs, ys, xy, xx, yy, dx, dy, col, row;
    longint k1, k2, p1, p2;
    bit ok;
    tcp_out_t r;
    ok = 1'b1;
    x = longint'(p.point_x);
    y = longint'(p.point_y);
    z = longint'(p.point_z);
    k1 = longint'(lens.radial_k1);
    k2 = longint'(lens.radial_k2);
    p1 = longint'(lens.tangential_p1);
    p2 = longint'(lens.tangential_p2);
    yr28 = y * longint'(COS_Q20) - z * longint'(SIN_Q20);
    zr28 = y * longint'(SIN_Q20) + z * longint'(COS_Q20);
    if (zr28 <= 0) return '0;
    zr16 = round_shift(zr28, 12);
    yr16 = round_shift(yr28, 12);
    x16 = x * 256;
    if (zr16 < 1) zr16 = 1;
    // SystemVerilog division truncates toward zero, as required here.
    xn = clip((x16 * ONE_Q24) / zr16, -NORM_LIM, NORM_LIM, ok);
    yn = clip((yr16 * ONE_Q24) / zr16, -NORM_LIM, NORM_LIM, ok);
    r2 = round_shift(xn * xn + yn * yn, 24);
    r4 = round_shift(r2 * r2, 24);
    r6 = round_shift(r4 * r2, 24);
    f = ONE_Q24 + round_shift(k1 * r2 + k2 * r4 + longint'(K3_Q16) * r6, 16);
    xs = clip(round_shift(xn * f, 24), -SCALED_LIM, SCALED_LIM, ok);
    ys = clip(round_shift(yn * f, 24), -SCALED_LIM, SCALED_LIM, ok);
    xy = round_shift(xs * ys, 24);
    xx = round_shift(xs * xs, 24);
    yy = round_shift(ys * ys, 24);
    dx = xs + round_shift(2 * p1 * xy + p2 * (r2 + 2 * xx), 16);
    dy = ys + round_shift(2 * p2 * xy + p1 * (r2 + 2 * yy), 16);
    col = round_shift(dx * longint'(lens.focal_x) + longint'(lens.center_x) * ONE_Q24, 28);
    row = round_shift(dy * longint'(lens.focal_y) + longint'(lens.center_y) * ONE_Q24, 28);
    col = clip(col, -32768, 32767, ok);
    row = clip(row, -32768, 32767, ok);
    r.pixel_col = 16'(col);
    r.pixel_row = 16'(row);
    r.valid_res = ok;
    return r;
  endfunction

  task automatic write_reg(tcp_reg_t idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FOCAL_X:  lens.focal_x = value[19:0];
      REG_FOCAL_Y:  lens.focal_y = value[19:0];
      REG_CENTER_X: lens.center_x = value[19:0];
      REG_CENTER_Y: lens.center_y = value[19:0];
      REG_K1:       lens.radial_k1 = value[17:0];
      REG_K2:       lens.radial_k2 = value[17:0];
      REG_P1:       lens.tangential_p1 = value[17:0];
      default:      lens.tangential_p2 = value[17:0];
    endcase
  endtask

  task automatic load_lens(tcp_cfg_t c);
    write_reg(REG_FOCAL_X, 32'(c.focal_x));
    write_reg(REG_FOCAL_Y, 32'(c.focal_y));
    write_reg(REG_CENTER_X, 32'(c.center_x));
    write_reg(REG_CENTER_Y, 32'(c.center_y));
    write_reg(REG_K1, 32'(c.radial_k1));
    write_reg(REG_K2, 32'(c.radial_k2));
    write_reg(REG_P1, 32'(c.tangential_p1));
    write_reg(REG_P2, 32'(c.tangential_p2));
  endtask

  // Waits until every expected word is back, then lets the pipeline drain.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Valid drops only when a gap follows, so back-to-back words keep it high.
  task automatic send_point(tcp_in_t p, bit typed, tcp_out_t want);
    tcp_out_t pred;
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pred = project_point(p);
    if (typed && pred != want)
      $error("typed row disagrees with prediction: %h vs %h", want, pred);
    if (typed) pred = want;
    pixel_queue.insert(pixel_queue.size(), pred);
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  function automatic tcp_in_t random_point();
    tcp_in_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.point_x = 24'($urandom);
    p.point_y = 24'($urandom);
    p.point_z = 24'($urandom);
    if (mode < 7) begin
      // Mostly points in front of the camera at moderate angles.
      p.point_z = 24'($urandom_range(256, 8388607));
      p.point_x = 24'(int'($urandom_range(0, 2 * (p.point_z >> 2))) - (p.point_z >> 2));
      p.point_y = 24'(int'($urandom_range(0, 2 * (p.point_z >> 2))) - (p.point_z >> 2));
    end else if (mode == 7) begin
      p.point_z = 24'($urandom_range(0, 64));
      p.point_y = 24'($urandom_range(0, 64));
    end
    return p;
  endfunction

  function automatic tcp_cfg_t random_lens();
    tcp_cfg_t c;
    c.focal_x = 20'($urandom);
    c.focal_y = 20'($urandom);
    c.center_x = 20'($urandom);
    c.center_y = 20'($urandom);
    c.radial_k1 = 18'($urandom) >>> $urandom_range(0, 4);
    c.radial_k2 = 18'($urandom) >>> $urandom_range(0, 4);
    c.tangential_p1 = 18'($urandom) >>> $urandom_range(0, 6);
    c.tangential_p2 = 18'($urandom) >>> $urandom_range(0, 6);
    return c;
  endfunction

  // Result side: random stalls, in-order field compare.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (!out_data.valid_res) invalid_seen++;
        if (pixel_queue.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          errors++;
        end else begin
          tcp_out_t want;
          want = pixel_queue.pop_front();
          if (out_data.pixel_col !== want.pixel_col) begin
            $error("pixel_col expected %0d actual %0d", want.pixel_col, out_data.pixel_col);
            errors++;
          end
          if (out_data.pixel_row !== want.pixel_row) begin
            $error("pixel_row expected %0d actual %0d", want.pixel_row, out_data.pixel_row);
            errors++;
          end
          if (out_data.valid_res !== want.valid_res) begin
            $error("valid_res expected %0b actual %0b", want.valid_res, out_data.valid_res);
            errors++;
          end
        end
      end
    end
  end

  // After each accepted word the result side drops out_ready for a random stall, which may be empty.
  int stall_left = 0;
  always @(posedge clk) begin
    if (out_ready && out_valid) begin
      stall_left = $urandom_range(0, 3);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (!stim_done || pixel_queue.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  point_row_t directed[$];
  tcp_cfg_t   extreme_lens;

  task automatic add_row(tcp_in_t pt, bit typed, tcp_out_t want);
    point_row_t row;
    row.pt = pt;
    row.typed = typed;
    row.want = want;
    directed.insert(directed.size(), row);
  endtask

  initial begin
    tcp_out_t none;
    none = '0;
    lens = '{focal_x: 20'd171408, focal_y: 20'd173694, center_x: 20'd106957,
             center_y: 20'd69024, radial_k1: 18'sd7128, radial_k2: -18'sd33192,
             tangential_p1: -18'sd1060, tangential_p2: 18'sd635};
    // A point straight ahead is pulled off center by the tilt; a depth at or
    // behind the camera gives an all-zero word.
    add_row('{24'sd0, 24'sd0, 24'sd256}, 1'b0, none);
    add_row('{24'sd0, 24'sd0, -24'sd256}, 1'b1, none);
    add_row('{24'sd0, 24'sd0, 24'sd0}, 1'b1, none);
    add_row('{24'sd100, 24'sd0, 24'sd0}, 1'b1, none);
    add_row('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b0, none);
    add_row('{-24'sh800000, -24'sh800000, -24'sh800000}, 1'b1, none);
    add_row('{-24'sh800000, 24'sd0, 24'sh7FFFFF}, 1'b0, none);
    add_row('{24'sh7FFFFF, 24'sd0, 24'sd1}, 1'b0, none);
    add_row('{24'sd1, 24'sd0, 24'sd1}, 1'b0, none);
    add_row('{24'sd0, 24'sd1, 24'sd0}, 1'b0, none);
    add_row('{24'sd0, -24'sh800000, 24'sh7FFFFF}, 1'b0, none);
    add_row('{24'sd0, 24'sh7FFFFF, 24'sd256}, 1'b0, none);
    add_row('{24'sd5000, 24'sd5000, 24'sd10000}, 1'b0, none);
    add_row('{-24'sd30000, 24'sd20000, 24'sd10000}, 1'b0, none);
    add_row('{24'sd2560, -24'sd2560, 24'sd2560}, 1'b0, none);
    add_row('{-24'sd1, -24'sd1, 24'sd512}, 1'b0, none);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_point(directed[i].pt, directed[i].typed, directed[i].want);
    drain_pipeline();

    // Extreme register values, then random lens sets between phases.
    extreme_lens = '{focal_x: 20'hFFFFF, focal_y: 20'd0, center_x: 20'hFFFFF, center_y: 20'd0,
                     radial_k1: 18'h1FFFF, radial_k2: 18'h20000,
                     tangential_p1: 18'h20000, tangential_p2: 18'h1FFFF};
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) load_lens(extreme_lens);
      else if (phase == 1) load_lens(~extreme_lens);
      else load_lens(random_lens());
      for (int i = 0; i < N_RANDOM / 6; i++) send_point(random_point(), 1'b0, none);
      for (int i = 0; i < 3; i++) send_point(directed[i + 4].pt, 1'b0, none);
      drain_pipeline();
    end
    stim_done = 1'b1;

    $display("Covered %0d points over 7 register settings; %0d words checked, %0d flagged invalid.",
             points_sent, words_seen, invalid_seen);
    if (errors == 0 && pixel_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tcp_pkg.sv
rtl/tcp_front.sv
rtl/tcp_div.sv
rtl/tcp_distort.sv
rtl/tcp_pixel.sv
rtl/tilted_camera_point_projection_unit.sv
rtl/tcp_checker.sv
tb/tilted_camera_point_projection_unit_test.sv
